### hdl/ievkp_pkg.sv
// Shared types, constants and key decode for the input event to pointer/keypad block.
package ievkp_pkg;

    // Free ring size used when the top level is not overridden.
    localparam int DEF_RING_SIZE = 16;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLET_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_DATA_W-1:0] RST_SCREEN_WIDTH  = 13'd800;
    localparam logic [CFG_DATA_W-1:0] RST_SCREEN_HEIGHT = 13'd480;

    // Event types, axis codes and the left button code.
    localparam logic [15:0] EVT_KEY     = 16'd1;
    localparam logic [15:0] EVT_ABS     = 16'd3;
    localparam logic [15:0] AXIS_X      = 16'd0;
    localparam logic [15:0] AXIS_Y      = 16'd1;
    localparam logic [15:0] BUTTON_LEFT = 16'h0110;

    // Keyboard codes that map to dense key ids.
    localparam logic [15:0] KC_UP        = 16'd103;
    localparam logic [15:0] KC_DOWN      = 16'd108;
    localparam logic [15:0] KC_LEFT      = 16'd105;
    localparam logic [15:0] KC_RIGHT     = 16'd106;
    localparam logic [15:0] KC_ENTER     = 16'd28;
    localparam logic [15:0] KC_BACKSPACE = 16'd14;
    localparam logic [15:0] KC_ESC       = 16'd1;
    localparam logic [15:0] KC_NEXT      = 16'd15;
    localparam logic [15:0] KC_END       = 16'd107;
    localparam logic [15:0] KC_HOME      = 16'd102;
    localparam logic [15:0] KC_DEL       = 16'd111;

    // Dense key ids; zero means the code is not mapped.
    localparam logic [3:0] KEY_NONE      = 4'd0;
    localparam logic [3:0] KEY_UP        = 4'd1;
    localparam logic [3:0] KEY_DOWN      = 4'd2;
    localparam logic [3:0] KEY_LEFT      = 4'd3;
    localparam logic [3:0] KEY_RIGHT     = 4'd4;
    localparam logic [3:0] KEY_ENTER     = 4'd5;
    localparam logic [3:0] KEY_BACKSPACE = 4'd6;
    localparam logic [3:0] KEY_ESC       = 4'd7;
    localparam logic [3:0] KEY_NEXT      = 4'd8;
    localparam logic [3:0] KEY_END       = 4'd9;
    localparam logic [3:0] KEY_HOME      = 4'd10;
    localparam logic [3:0] KEY_DEL       = 4'd11;

    // Scaling: position = value * size / 32767, saturating at 65535.
    localparam int PROD_W = 45;
    localparam logic [PROD_W-1:0] SAT_LIMIT = 45'd2147418112; // 65536 * 32767
    localparam logic [16:0] FULL_SCALE_1 = 17'd32767;
    localparam logic [16:0] FULL_SCALE_2 = 17'd65534;
    localparam logic [16:0] FULL_SCALE_3 = 17'd98301;

    // Decoded event carried from the input register to the result stage.
    typedef struct packed {
        logic       keep;      // buffer id is inside the ring
        logic       upd_x;
        logic       upd_y;
        logic       upd_btn;
        logic       upd_key;
        logic [3:0] key;
        logic       down;      // event value is nonzero
        logic [3:0] buf_id;
    } t_ctl;

    // Map a keyboard code to its dense key id.
    function automatic logic [3:0] map_key(input logic [15:0] code);
        logic [3:0] k;
        case (code)
            KC_UP:        k = KEY_UP;
            KC_DOWN:      k = KEY_DOWN;
            KC_LEFT:      k = KEY_LEFT;
            KC_RIGHT:     k = KEY_RIGHT;
            KC_ENTER:     k = KEY_ENTER;
            KC_BACKSPACE: k = KEY_BACKSPACE;
            KC_ESC:       k = KEY_ESC;
            KC_NEXT:      k = KEY_NEXT;
            KC_END:       k = KEY_END;
            KC_HOME:      k = KEY_HOME;
            KC_DEL:       k = KEY_DEL;
            default:      k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

### hdl/ievkp_if.sv
// Valid/ready channel interfaces for input events and result beats.
interface ievkp_event_if;
    logic        valid;
    logic        ready;
    logic [15:0] event_type;
    logic [15:0] event_code;
    logic [31:0] event_value;
    logic [15:0] buffer_id;

    modport source (output valid, event_type, event_code, event_value, buffer_id,
                    input ready);
    modport sink (input valid, event_type, event_code, event_value, buffer_id,
                  output ready);
endinterface

interface ievkp_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] pointer_x;
    logic [15:0] pointer_y;
    logic        pointer_down;
    logic [3:0]  key_id;
    logic        key_down;
    logic        recycle_valid;
    logic [3:0]  recycle_slot;
    logic [3:0]  recycle_buffer;
    logic [15:0] free_index;

    modport source (output valid, pointer_x, pointer_y, pointer_down, key_id, key_down,
                    recycle_valid, recycle_slot, recycle_buffer, free_index,
                    input ready);
    modport sink (input valid, pointer_x, pointer_y, pointer_down, key_id, key_down,
                  recycle_valid, recycle_slot, recycle_buffer, free_index,
                  output ready);
endinterface

### hdl/ievkp_scale.sv
// Divide a registered axis product by 32767 and saturate to 16 bits.
module ievkp_scale (
    input  logic [ievkp_pkg::PROD_W-1:0] i_prod,
    output logic [15:0]                  o_pos
);

    logic        sat;
    logic [15:0] hi;
    logic [14:0] lo;
    logic [16:0] sum;
    logic [1:0]  corr;
    logic [16:0] quo;

    // Any product at or above 65536 * 32767 saturates.
    assign sat = (i_prod >= ievkp_pkg::SAT_LIMIT);

    // p = hi * 32768 + lo = hi * 32767 + (hi + lo), so the quotient is
    // hi plus (hi + lo) / 32767, which is at most three.
    assign hi  = i_prod[30:15];
    assign lo  = i_prod[14:0];
    assign sum = {1'b0, hi} + {2'b00, lo};

    always_comb begin
        if (sum >= ievkp_pkg::FULL_SCALE_3) begin
            corr = 2'd3;
        end else if (sum >= ievkp_pkg::FULL_SCALE_2) begin
            corr = 2'd2;
        end else if (sum >= ievkp_pkg::FULL_SCALE_1) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
    end

    assign quo   = {1'b0, hi} + {15'd0, corr};
    assign o_pos = sat ? 16'hFFFF : quo[15:0];

endmodule

### hdl/input_event_to_pointer_keypad_top.sv
// Top level: input event decoder to pointer and keypad state with free-ring recycling.
//
// Input events arrive as beats on i_evt (valid/ready); one result beat leaves on
// o_res for every accepted event. A result carries the pointer and keypad state
// after that event, the recycle slot and buffer when the buffer id lies inside
// the ring, and the free ring producer index.
// The first stage registers the decoded event and the 32x13 axis product; the
// second divides by 32767, saturates and updates the state together with the
// result register. Throughput is one event per cycle while o_res.ready is high,
// set by the two pipeline registers.
// When the receiver stalls, the result register holds and the input stage can
// still take one more beat; after that i_evt.ready drops until o_res drains.
// Reset clears the pipeline and the state, sets screen size to 800 by 480,
// keyboard mode, and the producer index to the ring size. Configuration is
// written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write it only
// while idle, since the block itself does not enforce this.
module input_event_to_pointer_keypad_top #(
    parameter int RING_SIZE = ievkp_pkg::DEF_RING_SIZE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ievkp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ievkp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ievkp_event_if.sink                      i_evt,
    ievkp_result_if.source                   o_res
);

    localparam int SLOT_W = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_SIZE - 1);

    // Configuration registers.
    logic                             r_tablet_mode;
    logic [ievkp_pkg::CFG_DATA_W-1:0] r_screen_w;
    logic [ievkp_pkg::CFG_DATA_W-1:0] r_screen_h;

    // Input stage.
    logic                          r1_valid;
    ievkp_pkg::t_ctl               r1_ctl;
    logic [ievkp_pkg::PROD_W-1:0]  r1_prod;

    // State and result stage.
    logic        r_out_valid;
    logic [15:0] r_pos_x;
    logic [15:0] r_pos_y;
    logic        r_button_held;
    logic [3:0]  r_recent_key;
    logic        r_key_held;
    logic [15:0] r_free_prod;
    logic [SLOT_W-1:0] r_slot;
    logic        r_rec_valid;
    logic [3:0]  r_rec_slot;
    logic [3:0]  r_rec_buf;

    logic                          in_acc;
    logic                          s2_load;
    ievkp_pkg::t_ctl               n_ctl;
    logic [ievkp_pkg::PROD_W-1:0]  n_prod;
    logic [ievkp_pkg::CFG_DATA_W-1:0] axis_size;
    logic                          id_ok;
    logic                          is_abs;
    logic                          is_key;
    logic [3:0]                    key_map;
    logic [15:0]                   scaled;
    logic [SLOT_W-1:0]             n_slot;
    logic [15:0]                   slot_ext;

    // Handshake: the result stage loads when its register is free or draining.
    assign s2_load     = r1_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r1_valid || s2_load;
    assign in_acc      = i_evt.valid && i_evt.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tablet_mode <= 1'b0;
            r_screen_w    <= ievkp_pkg::RST_SCREEN_WIDTH;
            r_screen_h    <= ievkp_pkg::RST_SCREEN_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ievkp_pkg::CFG_TABLET_MODE:   r_tablet_mode <= i_cfg_data[0];
                ievkp_pkg::CFG_SCREEN_WIDTH:  r_screen_w    <= i_cfg_data;
                ievkp_pkg::CFG_SCREEN_HEIGHT: r_screen_h    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Event decode and axis product for the input register.
    assign id_ok     = (i_evt.buffer_id < 16'(RING_SIZE));
    assign is_abs    = (i_evt.event_type == ievkp_pkg::EVT_ABS);
    assign is_key    = (i_evt.event_type == ievkp_pkg::EVT_KEY);
    assign key_map   = ievkp_pkg::map_key(i_evt.event_code);
    assign axis_size = (i_evt.event_code == ievkp_pkg::AXIS_Y) ? r_screen_h : r_screen_w;
    assign n_prod    = ievkp_pkg::PROD_W'(i_evt.event_value)
                       * ievkp_pkg::PROD_W'(axis_size);

    always_comb begin
        n_ctl.keep    = id_ok;
        n_ctl.upd_x   = id_ok && r_tablet_mode && is_abs
                        && (i_evt.event_code == ievkp_pkg::AXIS_X);
        n_ctl.upd_y   = id_ok && r_tablet_mode && is_abs
                        && (i_evt.event_code == ievkp_pkg::AXIS_Y);
        n_ctl.upd_btn = id_ok && r_tablet_mode && is_key
                        && (i_evt.event_code == ievkp_pkg::BUTTON_LEFT);
        n_ctl.upd_key = id_ok && !r_tablet_mode && is_key
                        && (key_map != ievkp_pkg::KEY_NONE);
        n_ctl.key     = key_map;
        n_ctl.down    = (i_evt.event_value != 32'd0);
        n_ctl.buf_id  = i_evt.buffer_id[3:0];
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (in_acc) begin
            r1_valid <= 1'b1;
        end else if (s2_load) begin
            r1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_ctl  <= n_ctl;
            r1_prod <= n_prod;
        end
    end

    // Divide by full scale and saturate.
    ievkp_scale u_scale (
        .i_prod (r1_prod),
        .o_pos  (scaled)
    );

    // Ring slot follows the producer index modulo the ring size, restarting
    // when the 16-bit index wraps.
    always_comb begin
        if (r_free_prod == 16'hFFFF || r_slot == SLOT_LAST) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + SLOT_W'(1);
        end
    end

    assign slot_ext = 16'(r_slot);

    // Result stage: state update and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_pos_x       <= 16'd0;
            r_pos_y       <= 16'd0;
            r_button_held <= 1'b0;
            r_recent_key  <= ievkp_pkg::KEY_NONE;
            r_key_held    <= 1'b0;
            r_free_prod   <= 16'(RING_SIZE);
            r_slot        <= '0;
            r_rec_valid   <= 1'b0;
            r_rec_slot    <= 4'd0;
            r_rec_buf     <= 4'd0;
        end else begin
            if (s2_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (s2_load) begin
                if (r1_ctl.upd_x) begin
                    r_pos_x <= scaled;
                end
                if (r1_ctl.upd_y) begin
                    r_pos_y <= scaled;
                end
                if (r1_ctl.upd_btn) begin
                    r_button_held <= r1_ctl.down;
                end
                if (r1_ctl.upd_key) begin
                    r_recent_key <= r1_ctl.key;
                    r_key_held   <= r1_ctl.down;
                end
                r_rec_valid <= r1_ctl.keep;
                if (r1_ctl.keep) begin
                    r_rec_slot  <= slot_ext[3:0];
                    r_rec_buf   <= r1_ctl.buf_id;
                    r_free_prod <= r_free_prod + 16'd1;
                    r_slot      <= n_slot;
                end else begin
                    r_rec_slot <= 4'd0;
                    r_rec_buf  <= 4'd0;
                end
            end
        end
    end

    // Result beat.
    assign o_res.valid          = r_out_valid;
    assign o_res.pointer_x      = r_pos_x;
    assign o_res.pointer_y      = r_pos_y;
    assign o_res.pointer_down   = r_button_held;
    assign o_res.key_id         = r_recent_key;
    assign o_res.key_down       = r_key_held;
    assign o_res.recycle_valid  = r_rec_valid;
    assign o_res.recycle_slot   = r_rec_slot;
    assign o_res.recycle_buffer = r_rec_buf;
    assign o_res.free_index     = r_free_prod;

endmodule
